>>> hw/rtl/kqsb_pkg.sv
// ----------------------------------------------------------------------------
// kqsb_pkg
// Shared types, constants and helper functions for the shared-buffer queues.
// ----------------------------------------------------------------------------
package kqsb_pkg;

    localparam int ENTRIES = 16;
    localparam int QUEUES  = 4;
    localparam int PTR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LINK_W  = PTR_W + 1;
    localparam int QIDX_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int QID_W   = 2;
    localparam int DATA_W  = 32;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [QIDX_W-1:0] qidx_t;
    typedef logic [QID_W-1:0]  qid_t;

    localparam link_t LINK_NULL = {1'b1, {PTR_W{1'b0}}};

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_RD,
        S_ENQ_LINK,
        S_DEQ_RD,
        S_DEQ_UPD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic enq_rd;
        logic enq_link;
        logic deq_rd;
        logic deq_upd;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic req_ok;
        op_t  req_kind;
        logic out_stall;
    } dp_stat_t;

    function automatic logic link_ok(link_t l);
        return !l[LINK_W-1];
    endfunction

    // reset chain: entry i links to i+1, last entry is null
    function automatic link_t link_reset(ptr_t p);
        if (int'(p) + 1 < ENTRIES)
            return {1'b0, PTR_W'(int'(p) + 1)};
        else
            return LINK_NULL;
    endfunction

    function automatic qidx_t to_qidx(qid_t q);
        return QIDX_W'(q);
    endfunction

    function automatic logic queue_in_range(qid_t q);
        return int'(q) < QUEUES;
    endfunction

endpackage

>>> hw/rtl/kqsb_req_if.sv
// ----------------------------------------------------------------------------
// kqsb_req_if
// Request channel: operation kind, queue id and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface kqsb_req_if
    import kqsb_pkg::*;
();
    logic                     valid;
    logic                     ready;
    op_t                      kind;
    qid_t                     queue_id;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output kind, output queue_id, output value, input ready);
    modport sink   (input valid, input kind, input queue_id, input value, output ready);
endinterface

>>> hw/rtl/kqsb_rsp_if.sv
// ----------------------------------------------------------------------------
// kqsb_rsp_if
// Response channel: status and dequeued value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface kqsb_rsp_if
    import kqsb_pkg::*;
();
    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, output status, output read_value, input ready);
    modport sink   (input valid, input status, input read_value, output ready);
endinterface

>>> hw/rtl/kqsb_ctrl.sv
// ----------------------------------------------------------------------------
// kqsb_ctrl
// Controller state machine: sequences enqueue and dequeue steps of the datapath.
// ----------------------------------------------------------------------------
module kqsb_ctrl
    import kqsb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    priority if (!stat.req_ok)
                        state_next = S_DONE;
                    else if (stat.req_kind == OP_ENQ)
                        state_next = S_ENQ_RD;
                    else
                        state_next = S_DEQ_RD;
                end
            end
            S_ENQ_RD:   state_next = S_ENQ_LINK;
            S_ENQ_LINK: state_next = S_DONE;
            S_DEQ_RD:   state_next = S_DEQ_UPD;
            S_DEQ_UPD:  state_next = S_DONE;
            S_DONE:
            begin
                if (!stat.out_stall)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            S_ENQ_RD:   cmd.enq_rd   = 1'b1;
            S_ENQ_LINK: cmd.enq_link = 1'b1;
            S_DEQ_RD:   cmd.deq_rd   = 1'b1;
            S_DEQ_UPD:  cmd.deq_upd  = 1'b1;
            S_DONE:     cmd.load_result = !stat.out_stall;
            default:    cmd = '0;
        endcase
    end

endmodule

>>> hw/rtl/kqsb_dp.sv
// ----------------------------------------------------------------------------
// kqsb_dp
// Datapath: queue heads and tails, free list head, link and value stores,
// and the result register.
// ----------------------------------------------------------------------------
module kqsb_dp
    import kqsb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  op_t                      req_kind,
    input  qid_t                     req_queue_id,
    input  logic signed [DATA_W-1:0] req_value,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output status_t                  rsp_status,
    output logic signed [DATA_W-1:0] rsp_read_value
);

    // stores
    logic [DATA_W-1:0] entry_value_mem [ENTRIES];
    link_t             next_link_mem   [ENTRIES];

    // control state
    link_t               head_reg [QUEUES];
    link_t               head_next [QUEUES];
    link_t               tail_reg [QUEUES];
    link_t               tail_next [QUEUES];
    link_t               free_reg;
    link_t               free_next;
    logic [ENTRIES-1:0]  link_vld_reg;
    logic [ENTRIES-1:0]  link_vld_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    // item payload
    op_t                 kind_reg;
    qid_t                q_reg;
    logic [DATA_W-1:0]   value_reg;
    status_t             st_reg;
    link_t               entry_reg;
    link_t               link_rd_data_reg;
    ptr_t                link_rd_addr_reg;
    logic                link_rd_vld_reg;
    logic [DATA_W-1:0]   rdval_reg;
    status_t             out_status_reg;
    logic [DATA_W-1:0]   out_value_reg;

    qidx_t   qidx;
    qidx_t   req_qidx;
    link_t   req_head;
    logic    req_ok;
    status_t req_status;
    link_t   req_entry;
    ptr_t    eptr;
    link_t   link_rd;
    logic    link_we;
    ptr_t    link_wa;
    link_t   link_wd;

    assign qidx     = to_qidx(q_reg);
    assign req_qidx = to_qidx(req_queue_id);
    assign req_head = head_reg[req_qidx];
    assign eptr     = entry_reg[PTR_W-1:0];
    assign link_rd  = link_rd_vld_reg ? link_rd_data_reg : link_reset(link_rd_addr_reg);

    always_comb
    begin
        if (req_kind == OP_ENQ)
        begin
            req_ok     = queue_in_range(req_queue_id) && link_ok(free_reg);
            req_status = req_ok ? ST_OK : ST_FULL;
            req_entry  = free_reg;
        end
        else
        begin
            req_ok     = queue_in_range(req_queue_id) && link_ok(req_head);
            req_status = req_ok ? ST_OK : ST_EMPTY;
            req_entry  = req_head;
        end
    end

    assign stat.req_ok    = req_ok;
    assign stat.req_kind  = req_kind;
    assign stat.out_stall = out_valid_reg && !rsp_ready;

    // link store write port
    always_comb
    begin
        link_we = 1'b0;
        link_wa = eptr;
        link_wd = LINK_NULL;
        priority if (cmd.enq_rd)
        begin
            link_we = 1'b1;
            link_wa = eptr;
            link_wd = LINK_NULL;
        end
        else if (cmd.enq_link)
        begin
            link_we = link_ok(head_reg[qidx]) && link_ok(tail_reg[qidx]);
            link_wa = tail_reg[qidx][PTR_W-1:0];
            link_wd = entry_reg;
        end
        else if (cmd.deq_rd)
        begin
            link_we = 1'b1;
            link_wa = eptr;
            link_wd = free_reg;
        end
        else
        begin
            link_we = 1'b0;
        end
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        free_next     = free_reg;
        link_vld_next = link_vld_reg;
        if (link_we)
            link_vld_next[link_wa] = 1'b1;
        if (cmd.enq_link)
        begin
            free_next = link_rd;
            if (!link_ok(head_reg[qidx]))
                head_next[qidx] = entry_reg;
            tail_next[qidx] = entry_reg;
        end
        if (cmd.deq_rd)
            free_next = entry_reg;
        if (cmd.deq_upd)
            head_next[qidx] = link_rd;
        out_valid_next = out_valid_reg;
        priority if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= LINK_NULL;
                tail_reg[i] <= LINK_NULL;
            end
            free_reg      <= '0;
            link_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            link_vld_reg  <= link_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // link store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.enq_rd || cmd.deq_rd)
        begin
            link_rd_data_reg <= next_link_mem[eptr];
            link_rd_vld_reg  <= link_vld_reg[eptr];
            link_rd_addr_reg <= eptr;
        end
        if (link_we)
            next_link_mem[link_wa] <= link_wd;
    end

    // value store
    always_ff @(posedge clk)
    begin
        if (cmd.enq_rd)
            entry_value_mem[eptr] <= value_reg;
        if (cmd.deq_rd)
            rdval_reg <= entry_value_mem[eptr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg  <= req_kind;
            q_reg     <= req_queue_id;
            value_reg <= req_value;
            st_reg    <= req_status;
            entry_reg <= req_entry;
        end
        if (cmd.load_result)
        begin
            out_status_reg <= st_reg;
            out_value_reg  <= (kind_reg == OP_DEQ && st_reg == ST_OK) ? rdval_reg : '0;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_read_value = out_value_reg;

endmodule

>>> hw/rtl/k_queues_shared_buffer_top.sv
// ----------------------------------------------------------------------------
// k_queues_shared_buffer_top
// Several fifo queues sharing one entry store, linked through a next-link
// table, with a free list of unused entries.
// ----------------------------------------------------------------------------
// flow: an enqueue steps through enq read and enq link, a dequeue through deq
//   read and deq update (single link store write port, registered read); a
//   full or empty rejection goes straight to done; done waits while the prior
//   response stalls; one item in flight, new requests are taken only in idle
// reset: async active low; queues empty, free list chained 0..last, value store
//   undefined until written; no clearing pass, ready right after reset
module k_queues_shared_buffer_top
    import kqsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kqsb_req_if.sink    req,
    kqsb_rsp_if.source  rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    kqsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    kqsb_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_kind       (req.kind),
        .req_queue_id   (req.queue_id),
        .req_value      (req.value),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_status     (rsp.status),
        .rsp_read_value (rsp.read_value)
    );

endmodule

>>> hw/rtl/kqsb_checker.sv
// ----------------------------------------------------------------------------
// kqsb_checker
// Port-level checks for the shared-buffer queue block, bound to the top level.
// ----------------------------------------------------------------------------
module kqsb_checker
    import kqsb_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input status_t                  rsp_status,
    input logic signed [DATA_W-1:0] rsp_read_value
);

    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous item in flight");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_read_value))
        else $error("stalled response changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL
            || rsp_status == ST_EMPTY))
        else $error("response status out of range");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
        else $error("rejected item returned nonzero data");

endmodule

bind k_queues_shared_buffer_top kqsb_checker u_kqsb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_read_value (rsp.read_value)
);
